/* sv/bps_pkg.sv */
// battery power supervisor package: item structs, config struct, codes and constants
// no dependencies; used by every module of the block
package bps_pkg;

  // one battery poll tick
  typedef struct packed {
    logic [15:0] batt_mv;
    logic [6:0]  soc_pct;
    logic [7:0]  pack_status;
    logic [7:0]  bms_key;
    logic        link_error;
    logic        check_power_on;
    logic        loco_check_power;
    logic [11:0] motor_fault_bits;
  } bps_in_t;

  // one result item
  typedef struct packed {
    logic [7:0] status_out;
    logic [7:0] key_out;
    logic       board_link_fault;
    logic       loco_off;
    logic [2:0] boards_off;
    logic       supply_enable;
    logic       charging;
    logic       low_battery;
  } bps_out_t;

  // configuration register values
  typedef struct packed {
    logic [15:0] low_volt_mv;
    logic [6:0]  low_soc_pct;
    logic [7:0]  charge_confirm_ticks;
    logic [7:0]  low_bat_ticks;
  } bps_cfg_t;

  // supervisor flags
  typedef struct packed {
    logic       charging;
    logic       low_bat;
    logic       loco_off;
    logic [2:0] boards_off;
    logic       terminate;
  } bps_flags_t;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLT_MV   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SOC_PCT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAT_TICKS = 8'd3;

  localparam logic [15:0] RST_LOW_VOLT_MV   = 16'd18000;
  localparam logic [6:0]  RST_LOW_SOC_PCT   = 7'd15;
  localparam logic [7:0]  RST_CHARGE_TICKS  = 8'd10;
  localparam logic [7:0]  RST_LOW_BAT_TICKS = 8'd30;

  // sequence windows
  localparam int LOCO_OPEN   = 10;
  localparam int LOCO_CLOSE  = 40;
  localparam int BOARD_OPEN  = 20;
  localparam int BOARD_CLOSE = 80;

  localparam int STATUS_CHG_BIT = 0;
  localparam int KEY_BUTTON_BIT = 1;
  localparam logic [7:0] STATUS_LOW_MASK = 8'h02;
  localparam logic [7:0] KEY_SEQ_SET     = 8'h04;
  localparam logic [7:0] KEY_SEQ_CLR     = 8'hFB;
  localparam logic [2:0] BOARDS_ALL_OFF  = 3'd7;

  localparam int FAULT_W = 12;

endpackage

/* sv/bps_cfg.sv */
// battery power supervisor configuration registers
// depends on bps_pkg
module bps_cfg
  import bps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output bps_cfg_t              cfg
);

  bps_cfg_t cfg_r;
  bps_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOW_VOLT_MV:   cfg_nxt.low_volt_mv = cfg_data;
        CFG_LOW_SOC_PCT:   cfg_nxt.low_soc_pct = cfg_data[6:0];
        CFG_CHARGE_TICKS:  cfg_nxt.charge_confirm_ticks = cfg_data[7:0];
        CFG_LOW_BAT_TICKS: cfg_nxt.low_bat_ticks = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_volt_mv          <= RST_LOW_VOLT_MV;
      cfg_r.low_soc_pct          <= RST_LOW_SOC_PCT;
      cfg_r.charge_confirm_ticks <= RST_CHARGE_TICKS;
      cfg_r.low_bat_ticks        <= RST_LOW_BAT_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/bps_core.sv */
// battery power supervisor core: debounce and sequencing state plus per-tick result logic
// depends on bps_pkg
module bps_core
  import bps_pkg::*;
#(
  parameter int MOTOR_COUNT = 12,
  parameter int COUNT_WIDTH = 8
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  bps_in_t  item,
  input  bps_cfg_t cfg,
  output bps_out_t result
);

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam int MC_CHK = (MOTOR_COUNT > FAULT_W) ? FAULT_W : MOTOR_COUNT;

  logic [COUNT_WIDTH-1:0] charge_run_r, charge_run_nxt;
  logic [COUNT_WIDTH-1:0] low_run_r, low_run_nxt;
  logic [COUNT_WIDTH-1:0] loco_cnt_r, loco_cnt_nxt;
  logic [COUNT_WIDTH-1:0] board_cnt_r, board_cnt_nxt;
  bps_flags_t             flags_r, flags_nxt;

  logic [CMP_W-1:0] charge_run_x, loco_x, board_x;
  logic [CMP_W-1:0] charge_cfg_x, low_cfg_x;
  logic [CMP_W-1:0] low_run_cur_x;
  logic             offline;
  logic             board_ready;
  logic             supply;
  logic [7:0]       status;
  logic [7:0]       key;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // with more motors than the fault field holds, the block never reads as offline
  assign offline = (MOTOR_COUNT <= FAULT_W) && (&item.motor_fault_bits[MC_CHK-1:0]);

  assign charge_cfg_x  = CMP_W'(cfg.charge_confirm_ticks);
  assign low_cfg_x     = CMP_W'(cfg.low_bat_ticks);
  assign low_run_cur_x = CMP_W'(low_run_r);

  always_comb begin
    flags_nxt      = flags_r;
    charge_run_nxt = charge_run_r;
    low_run_nxt    = low_run_r;
    loco_cnt_nxt   = loco_cnt_r;
    board_cnt_nxt  = board_cnt_r;
    status         = item.pack_status;
    key            = item.bms_key;
    supply         = 1'b1;
    board_ready    = 1'b0;
    charge_run_x   = '0;
    loco_x         = '0;
    board_x        = '0;

    // charging debounce; a charge bit also clears low battery, which the low battery debounce may set again
    if (item.pack_status[STATUS_CHG_BIT]) begin
      flags_nxt.low_bat = 1'b0;
      charge_run_nxt = sat_inc(charge_run_r);
      charge_run_x = CMP_W'(charge_run_nxt);
      if (charge_run_x >= charge_cfg_x) begin
        flags_nxt.charging = 1'b1;
      end
    end else begin
      charge_run_nxt = '0;
      flags_nxt.charging = 1'b0;
    end

    // low battery debounce
    if (item.batt_mv <= cfg.low_volt_mv && item.soc_pct <= cfg.low_soc_pct) begin
      if (low_run_cur_x > low_cfg_x) begin
        flags_nxt.low_bat = 1'b1;
      end
      low_run_nxt = sat_inc(low_run_r);
    end else begin
      flags_nxt.low_bat = 1'b0;
      low_run_nxt = '0;
    end
    if (flags_nxt.low_bat) begin
      status = status | STATUS_LOW_MASK;
    end

    if (flags_nxt.charging) begin
      supply = 1'b0;
    end

    // locomotion power-down window
    if (item.check_power_on) begin
      if (!item.loco_check_power || CMP_W'(loco_cnt_r) < CMP_W'(LOCO_OPEN)) begin
        loco_cnt_nxt = sat_inc(loco_cnt_r);
      end
      loco_x = CMP_W'(loco_cnt_nxt);
      if (loco_x >= CMP_W'(LOCO_OPEN) && loco_x <= CMP_W'(LOCO_CLOSE)) begin
        if (item.loco_check_power) begin
          flags_nxt.loco_off = 1'b0;
        end
      end else if (loco_x > CMP_W'(LOCO_CLOSE)) begin
        flags_nxt.loco_off = 1'b1;
        key = key | KEY_SEQ_SET;
        flags_nxt.terminate = 1'b1;
      end
    end else begin
      loco_cnt_nxt = '0;
      key = key & KEY_SEQ_CLR;
      flags_nxt.loco_off = 1'b0;
      flags_nxt.boards_off = '0;
      flags_nxt.terminate = 1'b0;
    end

    // board power-down window
    if (item.check_power_on && item.loco_check_power && !flags_nxt.terminate) begin
      board_ready = offline && key[KEY_BUTTON_BIT];
      supply = 1'b0;
      if (!board_ready || CMP_W'(board_cnt_r) < CMP_W'(BOARD_OPEN)) begin
        board_cnt_nxt = sat_inc(board_cnt_r);
      end
      board_x = CMP_W'(board_cnt_nxt);
      if (board_x >= CMP_W'(BOARD_OPEN) && board_x <= CMP_W'(BOARD_CLOSE)) begin
        if (board_ready) begin
          flags_nxt.boards_off = '0;
          key = key | KEY_SEQ_SET;
        end
      end else if (board_x > CMP_W'(BOARD_CLOSE)) begin
        flags_nxt.boards_off = BOARDS_ALL_OFF;
        key = key | KEY_SEQ_SET;
      end
    end else begin
      board_cnt_nxt = '0;
    end
  end

  assign result.status_out       = status;
  assign result.key_out          = key;
  assign result.board_link_fault = item.link_error;
  assign result.loco_off         = flags_nxt.loco_off;
  assign result.boards_off       = flags_nxt.boards_off;
  assign result.supply_enable    = supply;
  assign result.charging         = flags_nxt.charging;
  assign result.low_battery      = flags_nxt.low_bat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_run_r <= '0;
      low_run_r    <= '0;
      loco_cnt_r   <= '0;
      board_cnt_r  <= '0;
      flags_r      <= '0;
    end else if (step) begin
      charge_run_r <= charge_run_nxt;
      low_run_r    <= low_run_nxt;
      loco_cnt_r   <= loco_cnt_nxt;
      board_cnt_r  <= board_cnt_nxt;
      flags_r      <= flags_nxt;
    end
  end

endmodule

/* sv/battery_power_supervisor.sv */
// battery power supervisor top level: input register, core logic, result register
// depends on bps_pkg, bps_cfg, bps_core
// an accepted item is held in the input register and moves on into the result register as soon
// as that register is free; out_data then shows its result until it is taken
// throughput: one item per cycle while out_ready holds; the input register and result register both advance together
// reset (rst_n low, synchronous): both pipeline stages empty, all counters and flags cleared,
// configuration registers back to their default thresholds
module battery_power_supervisor
  import bps_pkg::*;
#(
  parameter int MOTOR_COUNT = 12,
  parameter int COUNT_WIDTH = 8
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bps_in_t               in_data,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output bps_out_t              out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bps_cfg_t cfg;

  // input register stage
  logic     s1_valid_r, s1_valid_nxt;
  bps_in_t  s1_data_r;

  // result register stage
  logic     out_valid_r, out_valid_nxt;
  bps_out_t out_data_r;
  bps_out_t result;

  logic     in_fire;
  logic     advance;

  // item moves from the input register into the result register, updating state
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  // take a new item whenever the input register is empty or draining this cycle
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // debounce counters, sequence counters and flags live in the core
  bps_core #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

/* tb/bps_checker.sv */
`timescale 1ns / 1ps
// result checker for the battery power supervisor: watches all three channels,
// predicts each result item from its own copy of the state and compares. depends on bps_pkg
module bps_checker
  import bps_pkg::*;
#(
  parameter int MOTOR_COUNT = 12,
  parameter int COUNT_WIDTH = 8
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  bps_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  bps_out_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    results_checked,
  output int                    fail_count
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  bps_cfg_t               thr;
  logic [COUNT_WIDTH-1:0] charge_run;
  logic [COUNT_WIDTH-1:0] low_run;
  logic [COUNT_WIDTH-1:0] loco_cnt;
  logic [COUNT_WIDTH-1:0] board_cnt;
  logic                   charging_q;
  logic                   low_q;
  logic                   loco_off_q;
  logic [2:0]             boards_off_q;
  logic                   terminate_q;

  bps_out_t pending_reports[$];
  int       n_checked;
  int       n_fail;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // one poll tick through the supervisor rules, updating the shadow state
  function automatic bps_out_t supervise_tick(input bps_in_t t);
    bps_out_t           r;
    logic [7:0]         status;
    logic [7:0]         key;
    logic [FAULT_W-1:0] mask;
    logic               offline;
    logic               supply;
    logic               board_ready;
    status  = t.pack_status;
    key     = t.bms_key;
    supply  = 1'b1;
    mask    = (MOTOR_COUNT >= FAULT_W) ? '1 : FAULT_W'((1 << MOTOR_COUNT) - 1);
    offline = (MOTOR_COUNT <= FAULT_W) && ((t.motor_fault_bits & mask) == mask);

    // charge debounce, a charge bit always drops low battery first
    if (status[STATUS_CHG_BIT]) begin
      low_q = 1'b0;
      charge_run = bump(charge_run);
      if (charge_run >= thr.charge_confirm_ticks) charging_q = 1'b1;
    end else begin
      charge_run = '0;
      charging_q = 1'b0;
    end

    if (t.batt_mv <= thr.low_volt_mv && t.soc_pct <= thr.low_soc_pct) begin
      if (low_run > thr.low_bat_ticks) low_q = 1'b1;
      low_run = bump(low_run);
    end else begin
      low_q = 1'b0;
      low_run = '0;
    end
    if (low_q) status = status | STATUS_LOW_MASK;
    if (charging_q) supply = 1'b0;

    // locomotion window
    if (t.check_power_on) begin
      if (!t.loco_check_power || loco_cnt < LOCO_OPEN) loco_cnt = bump(loco_cnt);
      if (loco_cnt >= LOCO_OPEN && loco_cnt <= LOCO_CLOSE) begin
        if (t.loco_check_power) loco_off_q = 1'b0;
      end else if (loco_cnt > LOCO_CLOSE) begin
        loco_off_q  = 1'b1;
        key         = key | KEY_SEQ_SET;
        terminate_q = 1'b1;
      end
    end else begin
      loco_cnt     = '0;
      key          = key & KEY_SEQ_CLR;
      loco_off_q   = 1'b0;
      boards_off_q = '0;
      terminate_q  = 1'b0;
    end

    // board window
    if (t.check_power_on && t.loco_check_power && !terminate_q) begin
      board_ready = offline && key[KEY_BUTTON_BIT];
      supply = 1'b0;
      if (!board_ready || board_cnt < BOARD_OPEN) board_cnt = bump(board_cnt);
      if (board_cnt >= BOARD_OPEN && board_cnt <= BOARD_CLOSE) begin
        if (board_ready) begin
          boards_off_q = '0;
          key = key | KEY_SEQ_SET;
        end
      end else if (board_cnt > BOARD_CLOSE) begin
        boards_off_q = BOARDS_ALL_OFF;
        key = key | KEY_SEQ_SET;
      end
    end else begin
      board_cnt = '0;
    end

    r.status_out       = status;
    r.key_out          = key;
    r.board_link_fault = t.link_error;
    r.loco_off         = loco_off_q;
    r.boards_off       = boards_off_q;
    r.supply_enable    = supply;
    r.charging         = charging_q;
    r.low_battery      = low_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (n_fail < 10)
        $display("%0t result %0d: %s mismatch, expected 0x%0h actual 0x%0h",
                 $realtime, n_checked, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    bps_out_t want;
    if (!rst_n) begin
      thr.low_volt_mv          = RST_LOW_VOLT_MV;
      thr.low_soc_pct          = RST_LOW_SOC_PCT;
      thr.charge_confirm_ticks = RST_CHARGE_TICKS;
      thr.low_bat_ticks        = RST_LOW_BAT_TICKS;
      charge_run   = '0;
      low_run      = '0;
      loco_cnt     = '0;
      board_cnt    = '0;
      charging_q   = 1'b0;
      low_q        = 1'b0;
      loco_off_q   = 1'b0;
      boards_off_q = '0;
      terminate_q  = 1'b0;
      pending_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          if (n_fail < 10)
            $display("%0t unexpected result item 0x%0h", $realtime, out_data);
          n_fail++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status_out", want.status_out, out_data.status_out);
          check_field("key_out", want.key_out, out_data.key_out);
          check_field("board_link_fault", want.board_link_fault, out_data.board_link_fault);
          check_field("loco_off", want.loco_off, out_data.loco_off);
          check_field("boards_off", want.boards_off, out_data.boards_off);
          check_field("supply_enable", want.supply_enable, out_data.supply_enable);
          check_field("charging", want.charging, out_data.charging);
          check_field("low_battery", want.low_battery, out_data.low_battery);
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW_VOLT_MV:   thr.low_volt_mv          = cfg_data;
          CFG_LOW_SOC_PCT:   thr.low_soc_pct          = cfg_data[6:0];
          CFG_CHARGE_TICKS:  thr.charge_confirm_ticks = cfg_data[7:0];
          CFG_LOW_BAT_TICKS: thr.low_bat_ticks        = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_reports.push_back(supervise_tick(in_data));
    end
    results_checked <= n_checked;
    fail_count      <= n_fail;
  end

endmodule

/* tb/tb_battery_power_supervisor.sv */
`timescale 1ns / 1ps
// testbench top for battery_power_supervisor: clock, reset, stimulus and verdict
// depends on bps_pkg, the block and bps_checker
module tb_battery_power_supervisor;
  import bps_pkg::*;

  localparam int MOTORS = 12;
  localparam int CNT_W  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  bps_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bps_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int results_checked;
  int fail_count;

  // thresholds as last written, used to aim the stimulus
  logic [15:0] cur_volt;
  logic [6:0]  cur_soc;

  int   ticks_sent;
  logic steady = 1'b0;   // high: no idling on either side

  battery_power_supervisor #(
    .MOTOR_COUNT (MOTORS),
    .COUNT_WIDTH (CNT_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bps_checker #(
    .MOTOR_COUNT (MOTORS),
    .COUNT_WIDTH (CNT_W)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .results_checked (results_checked),
    .fail_count      (fail_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side back-pressure: unless steady, ready drops with a chance of about 27 in a hundred
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one tick item; valid stays up into the next item unless an idle cycle is drawn
  task automatic send_tick(input bps_in_t t);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop sending and wait until every result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (results_checked != ticks_sent) @(posedge clk);
  endtask

  // block must be idle here; also pokes an unused register index
  task automatic set_thresholds(input logic [15:0] volt, input logic [6:0] soc,
                                input logic [7:0] confirm, input logic [7:0] low_ticks);
    write_reg(CFG_LOW_VOLT_MV, volt);
    write_reg(CFG_LOW_SOC_PCT, {9'd0, soc});
    write_reg(CFG_CHARGE_TICKS, {8'd0, confirm});
    write_reg(CFG_LOW_BAT_TICKS, {8'd0, low_ticks});
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    cfg_valid <= 1'b0;
    cur_volt = volt;
    cur_soc  = soc;
  endtask

  function automatic bps_in_t mk_tick(input logic [15:0] mv, input logic [6:0] soc,
                                      input logic [7:0] status, input logic [7:0] key,
                                      input logic link, input logic check,
                                      input logic loco, input logic [11:0] faults);
    bps_in_t t;
    t.batt_mv          = mv;
    t.soc_pct          = soc;
    t.pack_status      = status;
    t.bms_key          = key;
    t.link_error       = link;
    t.check_power_on   = check;
    t.loco_check_power = loco;
    t.motor_fault_bits = faults;
    return t;
  endfunction

  // a run of ticks with one held pattern: power check held, locomotion level pattern,
  // charge bit, low/high battery, button and motors offline; some runs are pure noise
  task automatic run_episode(input int len);
    bps_in_t t;
    bit      noise;
    bit      hold_check;
    bit      btn_hold;
    bit      offl_hold;
    int      loco_mode;
    int      loco_delay;
    int      chg_mode;
    int      low_mode;
    noise      = ($urandom_range(0, 99) < 15);
    hold_check = ($urandom_range(0, 99) < 75);
    btn_hold   = ($urandom_range(0, 99) < 60);
    offl_hold  = ($urandom_range(0, 99) < 50);
    loco_mode  = $urandom_range(0, 3);
    loco_delay = $urandom_range(0, 50);
    chg_mode   = $urandom_range(0, 9);
    low_mode   = $urandom_range(0, 9);
    for (int k = 0; k < len; k++) begin
      t.batt_mv          = 16'($urandom_range(0, 16'hFFFF));
      t.soc_pct          = 7'($urandom_range(0, 100));
      t.pack_status      = 8'($urandom_range(0, 255));
      t.bms_key          = 8'($urandom_range(0, 255));
      t.link_error       = 1'($urandom_range(0, 1));
      t.check_power_on   = 1'($urandom_range(0, 1));
      t.loco_check_power = 1'($urandom_range(0, 1));
      t.motor_fault_bits = 12'($urandom_range(0, 12'hFFF));
      if (!noise) begin
        t.check_power_on = hold_check;
        case (loco_mode)
          0: t.loco_check_power = 1'b0;
          1: t.loco_check_power = 1'b1;
          2: t.loco_check_power = (k >= loco_delay);   // late locomotion report
          default: ;
        endcase
        if (chg_mode < 3) t.pack_status[STATUS_CHG_BIT] = 1'b1;
        else if (chg_mode < 7) t.pack_status[STATUS_CHG_BIT] = 1'b0;
        if (low_mode < 4) begin
          // both at or below thresholds
          t.batt_mv = 16'($urandom_range(0, cur_volt));
          t.soc_pct = 7'($urandom_range(0, (cur_soc > 100) ? 100 : cur_soc));
        end else if (low_mode < 7 && cur_volt != 16'hFFFF) begin
          t.batt_mv = 16'($urandom_range(cur_volt + 1, 16'hFFFF));
        end
        if (btn_hold) t.bms_key[KEY_BUTTON_BIT] = 1'b1;
        if (offl_hold) t.motor_fault_bits = '1;
      end
      send_tick(t);
    end
  endtask

  initial begin
    int target;
    int done_ticks;
    int len;
    int r;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    ticks_sent = 0;
    cur_volt   = RST_LOW_VOLT_MV;
    cur_soc    = RST_LOW_SOC_PCT;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset thresholds: field extremes, threshold edges
    send_tick(mk_tick(16'd0, 7'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'hFFFF, 7'd100, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 12'hFFF));
    send_tick(mk_tick(16'd18000, 7'd15, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd18001, 7'd15, 8'h00, 8'h04, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd18000, 7'd16, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd0, 7'd0, 8'h00, 8'h02, 1'b1, 1'b0, 1'b0, 12'h000));
    // power check, locomotion not reporting yet, motors offline with button
    send_tick(mk_tick(16'd20000, 7'd50, 8'h00, 8'h02, 1'b0, 1'b1, 1'b0, 12'hFFF));
    send_tick(mk_tick(16'd20000, 7'd50, 8'h00, 8'h02, 1'b0, 1'b1, 1'b1, 12'hFFF));
    // check dropped: sequences cleared, key bit2 cleared
    send_tick(mk_tick(16'd20000, 7'd50, 8'h00, 8'h06, 1'b0, 1'b0, 1'b1, 12'hFFF));
    send_tick(mk_tick(16'hA5A5, 7'd85, 8'hAA, 8'h55, 1'b0, 1'b1, 1'b0, 12'hAAA));
    send_tick(mk_tick(16'h5A5A, 7'd42, 8'h55, 8'hAA, 1'b1, 1'b0, 1'b1, 12'h555));
    drain();

    // zero charge confirm and zero low battery ticks
    set_thresholds(16'd18000, 7'd15, 8'd0, 8'd0);
    send_tick(mk_tick(16'd100, 7'd5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd100, 7'd5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    // charge bit while low: cleared then set again in the same tick
    send_tick(mk_tick(16'd100, 7'd5, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd30000, 7'd90, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));
    send_tick(mk_tick(16'd30000, 7'd90, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000));

    // random phases; state carries over so thresholds change mid-run
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: set_thresholds(16'hFFFF, 7'd100, 8'd255, 8'd254);   // long runs to saturation
        2: set_thresholds(16'd0, 7'd0, 8'd1, 8'd0);
        default: set_thresholds(16'($urandom_range(15000, 22000)), 7'($urandom_range(5, 40)),
                                8'($urandom_range(1, 20)), 8'($urandom_range(0, 40)));
      endcase
      steady <= (ph == 2);
      target = (ph == 1) ? 260 : 30;
      done_ticks = 0;
      while (done_ticks < target) begin
        r = $urandom_range(0, 99);
        if (ph == 1 && done_ticks == 0) len = $urandom_range(260, 280);
        else if (r < 15) len = $urandom_range(90, 140);   // past the board window
        else len = $urandom_range(5, 60);
        run_episode(len);
        done_ticks += len;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
